// ===== sv/wsp_pkg.sv =====
// Shared constants, command/status codes and sequencer states for the weighted site picker.
// No dependencies.
package wsp_pkg;

  localparam int unsigned MAX_SITES = 1024;
  localparam int unsigned ID_W      = 24;
  localparam int unsigned IDX_W     = $clog2(MAX_SITES);
  localparam int unsigned CNT_W     = $clog2(MAX_SITES + 1);
  localparam int unsigned SUM_W     = 63;
  localparam int unsigned MULT_W    = 16;
  localparam int unsigned RATE_W    = 32;
  localparam int unsigned PROD_W    = 64;

  localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_SITES);

  typedef enum logic [2:0] {
    CMD_ADD     = 3'd0,
    CMD_REMOVE  = 3'd1,
    CMD_CLEAR   = 3'd2,
    CMD_REBUILD = 3'd3,
    CMD_PICK    = 3'd4,
    CMD_LISTED  = 3'd5
  } cmd_e;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_FULL      = 2'd1,
    ST_NOT_FOUND = 2'd2,
    ST_EMPTY     = 2'd3
  } status_e;

  typedef enum logic [4:0] {
    S_IDLE, S_ADD_MUL, S_ADD_SUM,
    S_SCAN_RD, S_SCAN_CMP, S_RM_RDLAST, S_RM_WR, S_RM_SUB,
    S_RB_RD, S_RB_MUL, S_RB_ACC,
    S_PK_RDL, S_PK_MULH, S_PK_MULL, S_PK_TGT, S_PK_CHK, S_PK_CMP, S_PK_ID, S_PK_CAP,
    S_FIN
  } state_e;

  // saturating add of a weight onto an unsigned Q63.0 sum
  function automatic logic [SUM_W-1:0] sat_add(input logic [SUM_W-1:0] a,
                                               input logic [PROD_W-1:0] b);
    logic [PROD_W-1:0] s;
    s = {1'b0, a} + b;
    return s[PROD_W-1] ? {SUM_W{1'b1}} : s[SUM_W-1:0];
  endfunction

endpackage

// ===== sv/wsp_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module wsp_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end
endmodule

// ===== sv/wsp_mul.sv =====
// Shared 32x32 multiplier with registered product.
// Depends on wsp_pkg.
module wsp_mul (
  input  logic                        clk_i,
  input  logic [wsp_pkg::RATE_W-1:0]  a_i,
  input  logic [wsp_pkg::RATE_W-1:0]  b_i,
  output logic [wsp_pkg::PROD_W-1:0]  p_o
);
  import wsp_pkg::*;

  always_ff @(posedge clk_i) begin
    p_o <= PROD_W'(a_i) * PROD_W'(b_i);
  end
endmodule

// ===== sv/weighted_site_picker_core.sv =====
// Weighted site picker: site list, running total rate and prefix table, roulette pick.
// Depends on wsp_pkg, wsp_ram, wsp_mul.
// Items are taken one at a time: in_stall_o stays high until the sequencer is back in IDLE,
// and a result held by out_stall_i delays the next. Remove/is_listed scan the list in order;
// pick does a binary search of the prefix table.
// rst_ni (async, low) clears length, table length, total and rate_q; stores keep contents.
module weighted_site_picker_core (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_valid_i,
  output logic                        cfg_ready_o,
  input  logic [wsp_pkg::RATE_W-1:0]  cfg_data_i,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic [2:0]                  cmd_i,
  input  logic [wsp_pkg::ID_W-1:0]    site_id_i,
  input  logic [wsp_pkg::MULT_W-1:0]  multiplicity_i,
  input  logic [31:0]                 random_fraction_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic [wsp_pkg::ID_W-1:0]    picked_site_o,
  output logic                        found_o,
  output logic [1:0]                  status_o,
  output logic [wsp_pkg::SUM_W-1:0]   rate_sum_o,
  output logic [wsp_pkg::CNT_W-1:0]   site_count_o
);
  import wsp_pkg::*;

  state_e state_q, state_d;

  // architectural state
  logic [RATE_W-1:0] rate_q;
  logic [CNT_W-1:0]  len_q, tlen_q;
  logic [SUM_W-1:0]  sum_q;

  // item registers
  logic [2:0]        cmd_q;
  logic [ID_W-1:0]   id_q;
  logic [MULT_W-1:0] mult_q;
  logic [31:0]       frac_q;

  // working registers
  logic [CNT_W-1:0]  i_q, lo_q, hi_q;
  logic [IDX_W-1:0]  pos_q;
  logic [MULT_W-1:0] wpos_q;
  logic [SUM_W-1:0]  acc_q;
  logic [31:0]       last_lo_q;
  logic [PROD_W-1:0] tgt_q;
  logic [ID_W-1:0]   picked_q;
  logic              found_q;
  status_e           status_q;
  logic              out_valid_q;

  // memories and shared multiplier
  logic              id_we, w_we, c_we;
  logic [IDX_W-1:0]  waddr, raddr;
  logic [ID_W-1:0]   id_wdata, id_rdata;
  logic [MULT_W-1:0] w_wdata, w_rdata;
  logic [SUM_W-1:0]  c_wdata, c_rdata;
  logic [RATE_W-1:0] mul_a, mul_b;
  logic [PROD_W-1:0] mul_p;

  logic              in_fire, fin_go;
  logic [CNT_W-1:0]  mid, last_idx, lo_clamp;
  logic [SUM_W-1:0]  acc_next;

  assign cfg_ready_o = 1'b1;
  assign in_stall_o  = (state_q != S_IDLE);
  assign in_fire     = in_valid_i && (state_q == S_IDLE);
  assign fin_go      = !out_valid_q || !out_stall_i;
  assign mid         = lo_q + ((hi_q - lo_q) >> 1);
  assign last_idx    = len_q - CNT_W'(1);
  assign lo_clamp    = (lo_q >= tlen_q) ? (tlen_q - CNT_W'(1)) : lo_q;
  assign acc_next    = sat_add(acc_q, mul_p);

  wsp_ram #(.WIDTH(ID_W), .DEPTH(MAX_SITES)) u_ids (
    .clk_i, .we_i(id_we), .waddr_i(waddr), .wdata_i(id_wdata),
    .raddr_i(raddr), .rdata_o(id_rdata)
  );
  wsp_ram #(.WIDTH(MULT_W), .DEPTH(MAX_SITES)) u_wts (
    .clk_i, .we_i(w_we), .waddr_i(waddr), .wdata_i(w_wdata),
    .raddr_i(raddr), .rdata_o(w_rdata)
  );
  wsp_ram #(.WIDTH(SUM_W), .DEPTH(MAX_SITES)) u_cum (
    .clk_i, .we_i(c_we), .waddr_i(waddr), .wdata_i(c_wdata),
    .raddr_i(raddr), .rdata_o(c_rdata)
  );
  wsp_mul u_mul (.clk_i, .a_i(mul_a), .b_i(mul_b), .p_o(mul_p));

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (in_fire) begin
          case (cmd_i)
            CMD_ADD:     state_d = (len_q >= MAX_CNT) ? S_FIN : S_ADD_MUL;
            CMD_REMOVE:  state_d = S_SCAN_RD;
            CMD_LISTED:  state_d = S_SCAN_RD;
            CMD_REBUILD: state_d = S_RB_RD;
            CMD_PICK:    state_d = (tlen_q == '0) ? S_FIN : S_PK_RDL;
            default:     state_d = S_FIN;
          endcase
        end
      end
      S_ADD_MUL:   state_d = S_ADD_SUM;
      S_ADD_SUM:   state_d = S_FIN;
      S_SCAN_RD:   state_d = (i_q == len_q) ? S_FIN : S_SCAN_CMP;
      S_SCAN_CMP: begin
        if (id_rdata == id_q) begin
          state_d = (cmd_q == CMD_REMOVE) ? S_RM_RDLAST : S_FIN;
        end else begin
          state_d = S_SCAN_RD;
        end
      end
      S_RM_RDLAST: state_d = S_RM_WR;
      S_RM_WR:     state_d = S_RM_SUB;
      S_RM_SUB:    state_d = S_FIN;
      S_RB_RD:     state_d = (i_q == len_q) ? S_FIN : S_RB_MUL;
      S_RB_MUL:    state_d = S_RB_ACC;
      S_RB_ACC:    state_d = S_RB_RD;
      S_PK_RDL:    state_d = S_PK_MULH;
      S_PK_MULH:   state_d = S_PK_MULL;
      S_PK_MULL:   state_d = S_PK_TGT;
      S_PK_TGT:    state_d = S_PK_CHK;
      S_PK_CHK:    state_d = (lo_q < hi_q) ? S_PK_CMP : S_PK_ID;
      S_PK_CMP:    state_d = S_PK_CHK;
      S_PK_ID:     state_d = S_PK_CAP;
      S_PK_CAP:    state_d = S_FIN;
      S_FIN:       state_d = fin_go ? S_IDLE : S_FIN;
      default:     state_d = S_IDLE;
    endcase
  end

  // memory ports and multiplier operands
  always_comb begin
    id_we    = 1'b0;
    w_we     = 1'b0;
    c_we     = 1'b0;
    waddr    = pos_q;
    raddr    = i_q[IDX_W-1:0];
    id_wdata = id_rdata;
    w_wdata  = w_rdata;
    c_wdata  = acc_next;
    mul_a    = rate_q;
    mul_b    = RATE_W'(w_rdata);
    case (state_q)
      S_ADD_MUL: begin
        id_we    = 1'b1;
        w_we     = 1'b1;
        waddr    = len_q[IDX_W-1:0];
        id_wdata = id_q;
        w_wdata  = mult_q;
        mul_b    = RATE_W'(mult_q);
      end
      S_RM_RDLAST: raddr = last_idx[IDX_W-1:0];
      S_RM_WR: begin
        id_we = 1'b1;
        w_we  = 1'b1;
        mul_b = RATE_W'(wpos_q);
      end
      S_RB_ACC: begin
        c_we  = 1'b1;
        waddr = i_q[IDX_W-1:0];
      end
      S_PK_RDL: raddr = tlen_q[IDX_W-1:0] - IDX_W'(1);
      S_PK_MULH: begin
        mul_a = frac_q;
        mul_b = {1'b0, c_rdata[SUM_W-1:32]};
      end
      S_PK_MULL: begin
        mul_a = frac_q;
        mul_b = last_lo_q;
      end
      S_PK_CHK: raddr = mid[IDX_W-1:0];
      S_PK_ID:  raddr = lo_clamp[IDX_W-1:0];
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      rate_q      <= '0;
      len_q       <= '0;
      tlen_q      <= '0;
      sum_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_valid_i) begin
        rate_q <= cfg_data_i;
      end
      // a new beat is raised in FIN; an unaccepted beat stays up
      out_valid_q <= (state_q == S_FIN && fin_go) || (out_valid_q && out_stall_i);
      case (state_q)
        S_ADD_SUM: begin
          sum_q <= sat_add(sum_q, mul_p);
          len_q <= len_q + CNT_W'(1);
        end
        S_RM_SUB: begin
          sum_q <= (mul_p > PROD_W'(sum_q)) ? '0 : sum_q - mul_p[SUM_W-1:0];
          len_q <= last_idx;
        end
        S_RB_RD: begin
          if (i_q == len_q) tlen_q <= len_q;
        end
        S_IDLE: begin
          if (in_fire && cmd_i == CMD_CLEAR) begin
            len_q <= '0;
            sum_q <= '0;
          end
        end
        default: ;
      endcase
    end
  end

  // payload and working registers
  always_ff @(posedge clk_i) begin
    case (state_q)
      S_IDLE: begin
        if (in_fire) begin
          cmd_q    <= cmd_i;
          id_q     <= site_id_i;
          mult_q   <= multiplicity_i;
          frac_q   <= random_fraction_i;
          i_q      <= '0;
          acc_q    <= '0;
          picked_q <= '0;
          found_q  <= 1'b0;
          if (cmd_i == CMD_ADD && len_q >= MAX_CNT)    status_q <= ST_FULL;
          else if (cmd_i == CMD_PICK && tlen_q == '0)  status_q <= ST_EMPTY;
          else                                         status_q <= ST_OK;
        end
      end
      S_SCAN_RD: begin
        if (i_q == len_q && cmd_q == CMD_REMOVE) status_q <= ST_NOT_FOUND;
      end
      S_SCAN_CMP: begin
        if (id_rdata == id_q) begin
          pos_q   <= i_q[IDX_W-1:0];
          wpos_q  <= w_rdata;
          found_q <= (cmd_q == CMD_LISTED);
        end else begin
          i_q <= i_q + CNT_W'(1);
        end
      end
      S_RB_ACC: begin
        acc_q <= acc_next;
        i_q   <= i_q + CNT_W'(1);
      end
      S_PK_MULH: last_lo_q <= c_rdata[31:0];
      S_PK_MULL: tgt_q     <= mul_p;
      S_PK_TGT: begin
        tgt_q <= tgt_q + (mul_p >> 32);
        lo_q  <= '0;
        hi_q  <= tlen_q;
      end
      S_PK_CMP: begin
        if (PROD_W'(c_rdata) < tgt_q) lo_q <= mid + CNT_W'(1);
        else                          hi_q <= mid;
      end
      S_PK_CAP: picked_q <= id_rdata;
      default: ;
    endcase
    if (state_q == S_FIN && fin_go) begin
      picked_site_o <= picked_q;
      found_o       <= found_q;
      status_o      <= status_q;
      rate_sum_o    <= sum_q;
      site_count_o  <= len_q;
    end
  end

  assign out_valid_o = out_valid_q;

`ifndef NO_ASSERTIONS
  a_len_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    len_q <= MAX_CNT) else $error("site count exceeds capacity");
  a_tlen_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    tlen_q <= MAX_CNT) else $error("table length exceeds capacity");
  a_empty_pick: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && status_o == ST_EMPTY) |-> (picked_site_o == '0))
    else $error("empty-table pick returned a site");
`endif
endmodule

// ===== dv/tb_top.sv =====
// Self-checking bench for weighted_site_picker_core: site list, total rate, prefix table, pick.
// Depends on wsp_pkg and the core RTL; all stimulus and prediction live in this file.
module tb_top;
  import wsp_pkg::*;

  // reserved command codes, the core treats them as no-ops
  localparam logic [2:0] CMD_RSVD_LO = 3'd6;
  localparam logic [2:0] CMD_RSVD_HI = 3'd7;
  localparam int unsigned CYCLE_LIMIT = 4000000;
  localparam int unsigned DRAIN_CYCLES = 20;

  typedef struct packed {
    logic [2:0]        cmd;
    logic [ID_W-1:0]   site_id;
    logic [MULT_W-1:0] mult;
    logic [31:0]       frac;
  } site_op_t;

  typedef struct packed {
    logic [ID_W-1:0]  picked;
    logic             found;
    logic [1:0]       status;
    logic [SUM_W-1:0] total;
    logic [CNT_W-1:0] count;
  } site_resp_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_valid_i = 1'b0;
  logic cfg_ready_o;
  logic [RATE_W-1:0] cfg_data_i = '0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  logic [2:0] cmd_i = '0;
  logic [ID_W-1:0] site_id_i = '0;
  logic [MULT_W-1:0] multiplicity_i = '0;
  logic [31:0] random_fraction_i = '0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  logic [ID_W-1:0] picked_site_o;
  logic found_o;
  logic [1:0] status_o;
  logic [SUM_W-1:0] rate_sum_o;
  logic [CNT_W-1:0] site_count_o;

  always #6 clk_i = ~clk_i;

  weighted_site_picker_core dut (.*);

  // ---------------------------------------------------------------------------
  // Shadow copy of the site list, prefix table and rate register
  // ---------------------------------------------------------------------------
  logic [ID_W-1:0]   shadow_ids [MAX_SITES];
  logic [MULT_W-1:0] shadow_mults [MAX_SITES];
  logic [63:0]       shadow_prefix [MAX_SITES];
  int unsigned       shadow_len = 0;
  int unsigned       shadow_tbl_len = 0;
  logic [SUM_W-1:0]  shadow_sum = '0;
  logic [RATE_W-1:0] shadow_rate = '0;

  site_op_t   pending_ops[$];
  site_resp_t expected_resps[$];
  int unsigned mismatches = 0;
  int unsigned cmd_seen [8];
  int unsigned full_hits = 0, picks_ok = 0;

  function automatic logic [SUM_W-1:0] add_clamped(logic [SUM_W-1:0] a, logic [63:0] b);
    logic [63:0] s;
    s = {1'b0, a} + b;
    return s[63] ? {SUM_W{1'b1}} : s[SUM_W-1:0];
  endfunction

  // Applies one op to the shadow state and returns the response the core should give.
  function automatic site_resp_t apply_site_op(site_op_t op);
    site_resp_t r;
    logic [63:0] w, acc, last, hi, lo, tgt;
    int pos;
    int unsigned lo_i, hi_i, mid;
    r = '0;
    r.status = ST_OK;
    pos = -1;
    if (op.cmd == CMD_REMOVE || op.cmd == CMD_LISTED)
      for (int i = 0; i < shadow_len; i++)
        if (pos < 0 && shadow_ids[i] == op.site_id) pos = i;
    case (op.cmd)
      CMD_ADD: begin
        if (shadow_len >= MAX_SITES) begin
          r.status = ST_FULL;
          full_hits++;
        end else begin
          shadow_ids[shadow_len] = op.site_id;
          shadow_mults[shadow_len] = op.mult;
          shadow_len++;
          shadow_sum = add_clamped(shadow_sum, 64'(shadow_rate) * 64'(op.mult));
        end
      end
      CMD_REMOVE: begin
        if (pos < 0) begin
          r.status = ST_NOT_FOUND;
        end else begin
          w = 64'(shadow_rate) * 64'(shadow_mults[pos]);
          shadow_ids[pos] = shadow_ids[shadow_len-1];
          shadow_mults[pos] = shadow_mults[shadow_len-1];
          shadow_len--;
          // floor at zero: the rate may have changed since the add
          shadow_sum = (w > {1'b0, shadow_sum}) ? '0 : shadow_sum - w[SUM_W-1:0];
        end
      end
      CMD_CLEAR: begin
        shadow_len = 0;
        shadow_sum = '0;
      end
      CMD_REBUILD: begin
        acc = '0;
        for (int i = 0; i < shadow_len; i++) begin
          acc = {1'b0, add_clamped(acc[SUM_W-1:0], 64'(shadow_rate) * 64'(shadow_mults[i]))};
          shadow_prefix[i] = acc;
        end
        shadow_tbl_len = shadow_len;
      end
      CMD_PICK: begin
        if (shadow_tbl_len == 0) begin
          r.status = ST_EMPTY;
        end else begin
          // target = floor(frac * last / 2^32), split to stay inside 64 bits
          last = shadow_prefix[shadow_tbl_len-1];
          hi = last >> 32;
          lo = last & 64'hFFFF_FFFF;
          tgt = 64'(op.frac) * hi + ((64'(op.frac) * lo) >> 32);
          lo_i = 0;
          hi_i = shadow_tbl_len;
          while (lo_i < hi_i) begin
            mid = lo_i + ((hi_i - lo_i) >> 1);
            if (shadow_prefix[mid] < tgt) lo_i = mid + 1;
            else hi_i = mid;
          end
          if (lo_i >= shadow_tbl_len) lo_i = shadow_tbl_len - 1;
          // the table may be stale; ids come from the list store as it is now
          r.picked = shadow_ids[lo_i];
          picks_ok++;
        end
      end
      CMD_LISTED: r.found = (pos >= 0);
      default: ;
    endcase
    r.total = shadow_sum;
    r.count = CNT_W'(shadow_len);
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Driver: bursts of beats with random gaps; hold_ops freezes it between phases
  // ---------------------------------------------------------------------------
  logic hold_ops = 1'b0;
  int unsigned burst_left = 8, gap_left = 0;

  always @(posedge clk_i) begin
    site_op_t op;
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) begin
        expected_resps.insert(expected_resps.size(),
                              apply_site_op({cmd_i, site_id_i, multiplicity_i,
                                             random_fraction_i}));
        cmd_seen[cmd_i]++;
      end
      if (!in_valid_i || !in_stall_o) begin
        if (gap_left > 0) begin
          gap_left--;
          in_valid_i <= 1'b0;
        end else if (!hold_ops && pending_ops.size() > 0) begin
          op = pending_ops.pop_front();
          cmd_i <= op.cmd;
          site_id_i <= op.site_id;
          multiplicity_i <= op.mult;
          random_fraction_i <= op.frac;
          in_valid_i <= 1'b1;
          if (burst_left > 0) burst_left--;
          if (burst_left == 0) begin
            burst_left = $urandom_range(1, 40);
            // a third of the bursts run back to back
            gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 15);
          end
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor and receiver stall pattern
  // ---------------------------------------------------------------------------
  int unsigned stall_mode = 0, stall_phase = 0;

  always @(posedge clk_i) begin
    site_resp_t exp_r;
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        if (expected_resps.size() == 0) begin
          $error("result beat with nothing expected");
          mismatches++;
        end else begin
          exp_r = expected_resps.pop_front();
          if (picked_site_o !== exp_r.picked) begin
            $error("picked_site: expected %0h actual %0h", exp_r.picked, picked_site_o);
            mismatches++;
          end
          if (found_o !== exp_r.found) begin
            $error("found: expected %0h actual %0h", exp_r.found, found_o);
            mismatches++;
          end
          if (status_o !== exp_r.status) begin
            $error("status: expected %0h actual %0h", exp_r.status, status_o);
            mismatches++;
          end
          if (rate_sum_o !== exp_r.total) begin
            $error("rate_sum: expected %0h actual %0h", exp_r.total, rate_sum_o);
            mismatches++;
          end
          if (site_count_o !== exp_r.count) begin
            $error("site_count: expected %0h actual %0h", exp_r.count, site_count_o);
            mismatches++;
          end
        end
      end
      // switch between no stall, light stall and heavy stall, picked at random once per stall phase
      stall_phase++;
      if (stall_phase % 64 == 0) stall_mode = $urandom_range(0, 2);
      case (stall_mode)
        0: out_stall_i <= 1'b0;
        1: out_stall_i <= ($urandom_range(0, 9) < 3);
        default: out_stall_i <= ($urandom_range(0, 9) < 8);
      endcase
    end
  end

  int unsigned cycles = 0;
  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------
  task automatic wait_idle();
    hold_ops = 1'b0;
    do @(posedge clk_i);
    while (pending_ops.size() > 0 || in_valid_i || expected_resps.size() > 0);
    repeat (8) @(posedge clk_i);
  endtask

  task automatic write_rate(logic [RATE_W-1:0] value);
    @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_data_i <= value;
    do @(posedge clk_i);
    while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    shadow_rate = value;
  endtask

  task automatic queue_op(logic [2:0] cmd, logic [ID_W-1:0] id,
                          logic [MULT_W-1:0] mult, logic [31:0] frac);
    site_op_t op;
    op = {cmd, id, mult, frac};
    pending_ops.insert(pending_ops.size(), op);
  endtask

  // random op; ids mostly from a small pool so removes and lookups hit
  task automatic queue_random_op();
    int unsigned roll;
    logic [2:0] cmd;
    logic [ID_W-1:0] id;
    logic [MULT_W-1:0] mult;
    logic [31:0] frac;
    roll = $urandom_range(0, 99);
    if (roll < 30) cmd = CMD_ADD;
    else if (roll < 50) cmd = CMD_REMOVE;
    else if (roll < 53) cmd = CMD_CLEAR;
    else if (roll < 65) cmd = CMD_REBUILD;
    else if (roll < 90) cmd = CMD_PICK;
    else if (roll < 98) cmd = CMD_LISTED;
    else cmd = $urandom_range(0, 1) ? CMD_RSVD_HI : CMD_RSVD_LO;
    id = ($urandom_range(0, 3) == 0) ? ID_W'($urandom) : ID_W'($urandom_range(0, 31));
    roll = $urandom_range(0, 9);
    mult = (roll == 0) ? '0 : (roll == 1) ? '1 : MULT_W'($urandom);
    roll = $urandom_range(0, 9);
    frac = (roll == 0) ? '0 : (roll == 1) ? '1 : $urandom;
    queue_op(cmd, id, mult, frac);
  endtask

  task automatic run_mixed(int unsigned n);
    // first half, then a full drain before the second half
    hold_ops = 1'b1;
    repeat (n / 2) queue_random_op();
    wait_idle();
    hold_ops = 1'b1;
    repeat (n - n / 2) queue_random_op();
    wait_idle();
  endtask

  initial begin
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed: empty table, absent site, field extremes, stale and all-zero tables
    write_rate('1);
    hold_ops = 1'b1;
    queue_op(CMD_PICK, '0, '0, '1);
    queue_op(CMD_REMOVE, 24'h00_0007, '0, '0);
    queue_op(CMD_ADD, '0, '0, '0);
    queue_op(CMD_ADD, '1, '1, '0);
    queue_op(CMD_ADD, 24'h00_0005, 16'h0100, '0);
    queue_op(CMD_LISTED, '1, '0, '0);
    queue_op(CMD_LISTED, 24'h00_0007, '0, '0);
    queue_op(CMD_REBUILD, '0, '0, '0);
    queue_op(CMD_PICK, '0, '0, '0);
    queue_op(CMD_PICK, '0, '0, '1);
    queue_op(CMD_PICK, '0, '0, 32'h8000_0000);
    queue_op(CMD_REMOVE, '0, '0, '0);
    queue_op(CMD_PICK, '0, '0, '0);
    queue_op(CMD_CLEAR, '0, '0, '0);
    queue_op(CMD_PICK, '0, '0, 32'h4000_0000);
    queue_op(CMD_REBUILD, '0, '0, '0);
    queue_op(CMD_PICK, '0, '0, '0);
    queue_op(CMD_ADD, 24'h12_3456, '0, '0);
    queue_op(CMD_ADD, 24'h65_4321, '0, '0);
    queue_op(CMD_REBUILD, '0, '0, '0);
    queue_op(CMD_PICK, '0, '0, '1);
    queue_op(CMD_RSVD_LO, '1, '1, '1);
    queue_op(CMD_RSVD_HI, '0, '0, '0);
    queue_op(CMD_CLEAR, '0, '0, '0);
    wait_idle();

    write_rate(32'h0001_0000);
    run_mixed(280);
    write_rate('1);
    run_mixed(280);
    write_rate('0);
    run_mixed(200);
    write_rate($urandom);

    // fill the list to capacity, then hit it while full
    hold_ops = 1'b1;
    queue_op(CMD_CLEAR, '0, '0, '0);
    for (int i = 0; i < MAX_SITES + 6; i++) begin
      queue_op(CMD_ADD, ($urandom_range(0, 3) == 0) ? ID_W'($urandom) : ID_W'(i),
               MULT_W'($urandom), '0);
      if (i % 100 == 99) begin
        queue_op(CMD_REBUILD, '0, '0, '0);
        queue_op(CMD_PICK, '0, '0, $urandom);
      end
    end
    queue_op(CMD_REBUILD, '0, '0, '0);
    repeat (20) queue_random_op();
    queue_op(CMD_CLEAR, '0, '0, '0);
    wait_idle();

    write_rate(32'h0000_0001);
    run_mixed(60);

    repeat (DRAIN_CYCLES) @(posedge clk_i);
    $display("Covered %0d adds (%0d on a full list), %0d removes, %0d clears, %0d rebuilds",
             cmd_seen[CMD_ADD], full_hits, cmd_seen[CMD_REMOVE], cmd_seen[CMD_CLEAR],
             cmd_seen[CMD_REBUILD]);
    $display("  %0d picks (%0d from a filled table), %0d lookups, %0d reserved codes",
             cmd_seen[CMD_PICK], picks_ok, cmd_seen[CMD_LISTED],
             cmd_seen[CMD_RSVD_LO] + cmd_seen[CMD_RSVD_HI]);
    if (mismatches == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
sv/wsp_pkg.sv
sv/wsp_ram.sv
sv/wsp_mul.sv
sv/weighted_site_picker_core.sv
dv/tb_top.sv
